[rtl/s2i_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// s2i_pkg
// Shared types, character codes and helpers for the string to integer parser.
// ----------------------------------------------------------------------------
package s2i_pkg;

  // Defaults for the top-level parameters
  localparam int unsigned DEF_WIDTH     = 64;
  localparam int unsigned DEF_MAX_COUNT = 1023;

  // Result queue depth and width of the digit count field on the stream
  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned DIGITS_W   = 10;

  // Configuration register indexes
  localparam logic [1:0] REG_RADIX    = 2'd0;
  localparam logic [1:0] REG_SIGNED   = 2'd1;
  localparam logic [1:0] REG_SATURATE = 2'd2;

  // Bases
  localparam logic [5:0] RADIX_AUTO = 6'd0;
  localparam logic [5:0] RADIX_ONE  = 6'd1;
  localparam logic [5:0] RADIX_MAX  = 6'd36;
  localparam logic [5:0] BASE_BIN   = 6'd2;
  localparam logic [5:0] BASE_OCT   = 6'd8;
  localparam logic [5:0] BASE_DEC   = 6'd10;
  localparam logic [5:0] BASE_HEX   = 6'd16;
  localparam logic [5:0] DIGIT_NONE = 6'd63;

  // ASCII codes
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_DIG0  = 8'h30;
  localparam logic [7:0] CH_DIG9  = 8'h39;
  localparam logic [7:0] CH_UP_A  = 8'h41;
  localparam logic [7:0] CH_UP_B  = 8'h42;
  localparam logic [7:0] CH_UP_X  = 8'h58;
  localparam logic [7:0] CH_UP_Z  = 8'h5A;
  localparam logic [7:0] CH_LO_A  = 8'h61;
  localparam logic [7:0] CH_LO_B  = 8'h62;
  localparam logic [7:0] CH_LO_X  = 8'h78;
  localparam logic [7:0] CH_LO_Z  = 8'h7A;
  localparam logic [7:0] ALPHA_OFS = 8'd10;

  // Parse phases
  typedef enum logic [4:0] {
    PH_SPACE = 5'b00001,
    PH_LEAD  = 5'b00010,
    PH_ZERO  = 5'b00100,
    PH_DIGIT = 5'b01000,
    PH_STOP  = 5'b10000
  } s2i_phase_t;

  typedef struct packed {
    logic [5:0] radix;
    logic       signed_result;
    logic       saturate;
  } s2i_cfg_t;

  typedef struct packed {
    logic                bad_radix;
    logic                overflowed;
    logic [DIGITS_W-1:0] digits;
  } s2i_status_t;

  // Digit value of a character, DIGIT_NONE for anything that is not 0-9, a-z, A-Z
  function automatic logic [5:0] char_digit(input logic [7:0] c);
    logic [5:0] d;
    d = DIGIT_NONE;
    if (c >= CH_DIG0 && c <= CH_DIG9) begin
      d = 6'(c - CH_DIG0);
    end else if (c >= CH_LO_A && c <= CH_LO_Z) begin
      d = 6'(c - CH_LO_A + ALPHA_OFS);
    end else if (c >= CH_UP_A && c <= CH_UP_Z) begin
      d = 6'(c - CH_UP_A + ALPHA_OFS);
    end
    return d;
  endfunction

endpackage

[rtl/s2i_parser.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// s2i_parser
// Input register, parse state and the combinational step that updates the
// state for one character or builds the result at string end.
// ----------------------------------------------------------------------------
module s2i_parser import s2i_pkg::*; #(
  parameter int unsigned WIDTH     = DEF_WIDTH,
  parameter int unsigned MAX_COUNT = DEF_MAX_COUNT
) (
  input  logic             clk,
  input  logic             rst,
  input  s2i_cfg_t         cfg,
  input  logic             in_take,
  input  logic [7:0]       in_ch,
  input  logic             in_end,
  output logic             pend_end,
  output logic             res_valid,
  output logic [WIDTH-1:0] res_value,
  output s2i_status_t      res_status
);

  localparam int unsigned CNT_W = $clog2(MAX_COUNT + 1);
  localparam int unsigned PRD_W = WIDTH + 6;
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_COUNT);
  localparam logic [WIDTH-1:0] SMAX = {1'b0, {(WIDTH-1){1'b1}}};
  localparam logic [WIDTH-1:0] SMIN = {1'b1, {(WIDTH-1){1'b0}}};
  localparam logic [WIDTH-1:0] UMAX = {WIDTH{1'b1}};

  // Input register
  logic       stage_valid;
  logic [7:0] ch_q;
  logic       end_q;

  // Parse state
  s2i_phase_t       phase, phase_next;
  logic [WIDTH-1:0] acc, acc_next;
  logic             neg, neg_next;
  logic             ovf_seen, ovf_seen_next;
  logic [5:0]       base, base_next;
  logic [CNT_W-1:0] count, count_next;

  // Capture the accepted transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else begin
      stage_valid <= in_take;
    end
    if (in_take) begin
      ch_q  <= in_ch;
      end_q <= in_end;
    end
  end

  assign pend_end  = stage_valid & end_q;
  assign res_valid = stage_valid & end_q;

  // Advance the parse state by one character
  always_comb begin
    logic             bad;
    logic             take;
    logic [5:0]       digit;
    logic [PRD_W-1:0] prod;
    logic [5:0]       dflt_base;

    bad       = (cfg.radix == RADIX_ONE) || (cfg.radix > RADIX_MAX);
    digit     = char_digit(ch_q);
    take      = 1'b0;
    prod      = '0;
    dflt_base = (cfg.radix == RADIX_AUTO) ? BASE_DEC : cfg.radix;

    phase_next    = phase;
    acc_next      = acc;
    neg_next      = neg;
    ovf_seen_next = ovf_seen;
    base_next     = base;
    count_next    = count;

    if (stage_valid && !end_q && !bad) begin
      case (phase)
        PH_SPACE: begin
          if (ch_q == CH_MINUS) begin
            phase_next = PH_LEAD;
            neg_next   = 1'b1;
          end else if (ch_q == CH_PLUS) begin
            phase_next = PH_LEAD;
          end else if (ch_q == CH_DIG0) begin
            phase_next = PH_ZERO;
          end else if (ch_q != CH_SPACE) begin
            base_next  = dflt_base;
            phase_next = PH_DIGIT;
            take       = 1'b1;
          end
        end
        PH_LEAD: begin
          if (ch_q == CH_DIG0) begin
            phase_next = PH_ZERO;
          end else begin
            base_next  = dflt_base;
            phase_next = PH_DIGIT;
            take       = 1'b1;
          end
        end
        PH_ZERO: begin
          phase_next = PH_DIGIT;
          if ((cfg.radix == RADIX_AUTO || cfg.radix == BASE_HEX) &&
              (ch_q == CH_LO_X || ch_q == CH_UP_X)) begin
            base_next = BASE_HEX;
          end else if ((cfg.radix == RADIX_AUTO || cfg.radix == BASE_BIN) &&
                       (ch_q == CH_LO_B || ch_q == CH_UP_B)) begin
            base_next = BASE_BIN;
          end else begin
            // lone leading zero counts as a digit
            base_next  = (cfg.radix == RADIX_AUTO) ? BASE_OCT : cfg.radix;
            count_next = (count < CNT_MAX) ? count + 1'b1 : count;
            take       = 1'b1;
          end
        end
        PH_DIGIT: begin
          take = 1'b1;
        end
        default: begin
        end
      endcase

      // Accumulate one digit; the product overflows iff its top bits are set
      if (take) begin
        if (base_next < BASE_BIN || base_next > RADIX_MAX || digit >= base_next) begin
          phase_next = PH_STOP;
        end else begin
          count_next = (count_next < CNT_MAX) ? count_next + 1'b1 : count_next;
          if (!ovf_seen) begin
            prod = PRD_W'(acc) * PRD_W'(base_next) + PRD_W'(digit);
            if (|prod[PRD_W-1:WIDTH]) begin
              ovf_seen_next = 1'b1;
            end else begin
              acc_next = prod[WIDTH-1:0];
            end
          end
        end
      end
    end

    // String end returns the parse state to its start
    if (stage_valid && end_q) begin
      phase_next    = PH_SPACE;
      acc_next      = '0;
      neg_next      = 1'b0;
      ovf_seen_next = 1'b0;
      base_next     = '0;
      count_next    = '0;
    end
  end

  // Build the result from the state left by the last character
  always_comb begin
    logic                  bad;
    logic                  ovf;
    logic [CNT_W-1:0]      cnt;
    logic [WIDTH-1:0]      val;
    logic [CNT_W+DIGITS_W-1:0] cnt_ext;

    bad = (cfg.radix == RADIX_ONE) || (cfg.radix > RADIX_MAX);
    cnt = count;
    if (phase == PH_ZERO && cnt < CNT_MAX) begin
      cnt = count + 1'b1;
    end
    ovf = ovf_seen;
    if (!ovf && cfg.signed_result) begin
      ovf = neg ? (acc > SMIN) : (acc > SMAX);
    end
    val = neg ? (~acc + 1'b1) : acc;
    if (ovf) begin
      if (cfg.saturate) begin
        if (cfg.signed_result) begin
          val = neg ? SMIN : SMAX;
        end else begin
          val = neg ? '0 : UMAX;
        end
      end else begin
        val = '0;
        cnt = '0;
      end
    end
    if (bad) begin
      val = '0;
      cnt = '0;
      ovf = 1'b0;
    end
    cnt_ext               = {{DIGITS_W{1'b0}}, cnt};
    res_value             = val;
    res_status.bad_radix  = bad;
    res_status.overflowed = ovf;
    res_status.digits     = cnt_ext[DIGITS_W-1:0];
  end

  // Hold the parse state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= PH_SPACE;
      acc      <= '0;
      neg      <= 1'b0;
      ovf_seen <= 1'b0;
      base     <= '0;
      count    <= '0;
    end else begin
      phase    <= phase_next;
      acc      <= acc_next;
      neg      <= neg_next;
      ovf_seen <= ovf_seen_next;
      base     <= base_next;
      count    <= count_next;
    end
  end

endmodule

[rtl/s2i_out_fifo.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// s2i_out_fifo
// Small result queue that drives the output stream and reports its level.
// ----------------------------------------------------------------------------
module s2i_out_fifo import s2i_pkg::*; #(
  parameter int unsigned DATA_W = 80
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           push,
  input  logic [DATA_W-1:0]              push_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [DATA_W-1:0]              out_data,
  output logic [$clog2(FIFO_DEPTH+1)-1:0] level
);

  localparam int unsigned PTR_W = $clog2(FIFO_DEPTH);
  localparam int unsigned LVL_W = $clog2(FIFO_DEPTH + 1);

  logic [DATA_W-1:0] mem [FIFO_DEPTH];
  logic [PTR_W-1:0]  wr_ptr, rd_ptr;
  logic              pop;

  assign out_valid = (level != '0);
  assign out_data  = mem[rd_ptr];
  assign pop       = out_valid & out_ready;

  // Store results
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  // Advance pointers and level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      level <= level + LVL_W'(push) - LVL_W'(pop);
    end
  end

endmodule

[rtl/string_to_integer_parser_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// string_to_integer_parser_core
// Parses an integer from a character stream in the manner of strtol.
//
//   Channel | Dir | Handshake        | Contents
//   s_*     | in  | s_tvalid/s_tready| tdata: ch; tlast: string end
//   m_*     | out | m_tvalid/m_tready| tdata: value, digits, overflow, bad radix
//   cfg_*   | in  | cfg_we           | register index and write data
//
// One character per cycle is accepted while s_tready is high. A character
// is registered, then applied to the parse state in the next cycle by one
// multiply-add and compare. A result then goes through the result queue to
// m_tvalid; the four-entry queue absorbs stalls on m_*, and s_tready drops only
// when queued and in-flight results would fill it. Reset is synchronous.
// ----------------------------------------------------------------------------
module string_to_integer_parser_core import s2i_pkg::*; #(
  parameter int unsigned WIDTH     = DEF_WIDTH,
  parameter int unsigned MAX_COUNT = DEF_MAX_COUNT
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   s_tvalid,
  output logic                                   s_tready,
  input  logic [7:0]                             s_tdata,  // [7:0] ch
  input  logic                                   s_tlast,
  output logic                                   m_tvalid,
  input  logic                                   m_tready,
  // value, digits_consumed (10), overflowed, bad_radix, zero pad
  output logic [((WIDTH+DIGITS_W+2+7)/8)*8-1:0]  m_tdata,
  input  logic                                   cfg_we,
  input  logic [1:0]                             cfg_addr,
  input  logic [5:0]                             cfg_wdata
);

  localparam int unsigned OUT_W = ((WIDTH + DIGITS_W + 2 + 7) / 8) * 8;
  localparam int unsigned LVL_W = $clog2(FIFO_DEPTH + 1);

  s2i_cfg_t         cfg;
  logic             in_take;
  logic             pend_end;
  logic             res_valid;
  logic [WIDTH-1:0] res_value;
  s2i_status_t      res_status;
  logic [LVL_W-1:0] level;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.radix         <= RADIX_AUTO;
      cfg.signed_result <= 1'b1;
      cfg.saturate      <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_RADIX:    cfg.radix         <= cfg_wdata;
        REG_SIGNED:   cfg.signed_result <= cfg_wdata[0];
        REG_SATURATE: cfg.saturate      <= cfg_wdata[0];
        default: begin
        end
      endcase
    end
  end

  // Accept while queued plus in-flight results leave a free entry
  assign s_tready = (level + LVL_W'(pend_end)) < LVL_W'(FIFO_DEPTH);
  assign in_take  = s_tvalid & s_tready;

  s2i_parser #(
    .WIDTH     (WIDTH),
    .MAX_COUNT (MAX_COUNT)
  ) u_parser (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .in_take    (in_take),
    .in_ch      (s_tdata),
    .in_end     (s_tlast),
    .pend_end   (pend_end),
    .res_valid  (res_valid),
    .res_value  (res_value),
    .res_status (res_status)
  );

  s2i_out_fifo #(
    .DATA_W (OUT_W)
  ) u_out_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (res_valid),
    .push_data (OUT_W'({res_status.bad_radix, res_status.overflowed,
                        res_status.digits, res_value})),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (m_tdata),
    .level     (level)
  );

`ifndef SYNTHESIS
  // A string-end transaction shows up as a pending result in the next cycle
  a_end_to_pending: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && s_tlast) |=> pend_end)
    else $error("string end not registered");

  // Never push into a full queue unless it pops in the same cycle
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (level < LVL_W'(FIFO_DEPTH) || (m_tvalid && m_tready)))
    else $error("result queue overrun");

  // A bad radix yields an all-zero result
  a_bad_radix_zero: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_status.bad_radix) |->
      (res_value == '0 && res_status.digits == '0 && !res_status.overflowed))
    else $error("bad radix result not zero");

  // Overflow without saturation reports no digits
  a_ovf_no_digits: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_status.overflowed && !cfg.saturate) |->
      (res_status.digits == '0 && res_value == '0))
    else $error("overflow without saturation kept digits");
`endif

endmodule
